// File: hdl/nps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the nearest polyline search
// Widths of the channel payloads, default parameters and the job record that
// travels from the front end to the distance engine.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int IN_COORD_W          = 16;
  localparam int INDEX_OUT_W         = 16;
  localparam int DIST_OUT_W          = 33;
  localparam int PATH_INDEX_BITS_DEF = 16;
  localparam int COORD_BITS_DEF      = 16;
  localparam int QUEUE_DEPTH_DEF     = 2;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_VERTEX = 1'b1
  } op_t;

  typedef logic [IN_COORD_W-1:0] coord_t;

  typedef struct packed {
    op_t    op;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    logic   seg;
    logic   path_end;
    logic   path_valid;
    logic   search_last;
  } job_t;

endpackage

// File: hdl/nps_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_in_if: command and vertex channel
// Valid/ready channel carrying start commands and path vertices.
// ----------------------------------------------------------------------------
interface nps_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic signed [nps_pkg::IN_COORD_W-1:0] x;
  logic signed [nps_pkg::IN_COORD_W-1:0] y;
  logic                             path_last;
  logic                             search_last;

  modport source (output valid, cmd, x, y, path_last, search_last, input ready);
  modport sink   (input valid, cmd, x, y, path_last, search_last, output ready);
endinterface

// File: hdl/nps_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_out_if: search result channel
// Valid/ready channel carrying the nearest path of one search.
// ----------------------------------------------------------------------------
interface nps_out_if;
  logic                           valid;
  logic                           ready;
  logic [nps_pkg::INDEX_OUT_W-1:0] best_index;
  logic [nps_pkg::DIST_OUT_W-1:0]  min_sq_dist;
  logic                           found;

  modport source (output valid, best_index, min_sq_dist, found, input ready);
  modport sink   (input valid, best_index, min_sq_dist, found, output ready);
endinterface

// File: hdl/nps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_front: input classifier
// Accepts commands and vertices, tracks the previous vertex and the vertex
// count of the open path, and turns each transaction into a job record.
// ----------------------------------------------------------------------------
module nps_front (
  input  logic           clk,
  input  logic           rst_n,
  nps_in_if.sink         in_ch,
  output nps_pkg::job_t  job,
  output logic           job_valid,
  input  logic           job_ready
);

  logic [nps_pkg::IN_COORD_W-1:0] prev_x_r, prev_y_r;
  logic [1:0]                     verts_r, verts_nxt;
  logic                           accept, is_start, ends;

  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid;
  assign accept      = in_ch.valid && job_ready;
  assign is_start    = (in_ch.cmd == nps_pkg::OP_START);
  assign ends        = !is_start && (in_ch.path_last || in_ch.search_last);

  always_comb begin
    job.op          = is_start ? nps_pkg::OP_START : nps_pkg::OP_VERTEX;
    job.ax          = is_start ? in_ch.x : prev_x_r;
    job.ay          = is_start ? in_ch.y : prev_y_r;
    job.bx          = in_ch.x;
    job.by          = in_ch.y;
    job.seg         = !is_start && (verts_r != 2'd0);
    job.path_end    = ends;
    job.path_valid  = (verts_r != 2'd0);
    job.search_last = !is_start && in_ch.search_last;
  end

  always_comb begin
    verts_nxt = verts_r;
    if (is_start || ends) begin
      verts_nxt = 2'd0;
    end else if (verts_r != 2'd2) begin
      verts_nxt = verts_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verts_r <= 2'd0;
    end else if (accept) begin
      verts_r <= verts_nxt;
    end
    if (accept && !is_start) begin
      prev_x_r <= in_ch.x;
      prev_y_r <= in_ch.y;
    end
  end

endmodule

// File: hdl/nps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_queue: job queue
// Short FIFO of job records between the classifier and the distance engine.
// ----------------------------------------------------------------------------
module nps_queue #(
  parameter int DEPTH = nps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  nps_pkg::job_t push_job,
  input  logic          push_valid,
  output logic          push_ready,
  output nps_pkg::job_t pop_job,
  output logic          pop_valid,
  input  logic          pop_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  nps_pkg::job_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: hdl/nps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_back: segment distance engine
// Computes the squared point-to-segment distance of each job, with a
// shift-add squarer and a restoring divider for the interior case, and keeps
// the per-path and per-search minimum and the result register.
// ----------------------------------------------------------------------------
module nps_back #(
  parameter int PATH_INDEX_BITS = nps_pkg::PATH_INDEX_BITS_DEF,
  parameter int COORD_BITS      = nps_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  nps_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  nps_out_if.source     out_ch
);

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;
  localparam int PRW = 2 * DW;
  localparam int SGW = PRW + 1;
  localparam int SW  = 2 * C + 2;
  localparam int MW  = SW;
  localparam int QW  = 2 * MW;
  localparam int CW  = $clog2(QW + 1);
  localparam int P   = PATH_INDEX_BITS;
  localparam int IW  = nps_pkg::INDEX_OUT_W;
  localparam int OW  = nps_pkg::DIST_OUT_W;
  localparam logic [SW-1:0] DIST_ONES = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_CLS, S_SQ, S_DIV, S_UPD
  } state_t;

  function automatic logic signed [DW-1:0] to_coord(input nps_pkg::coord_t v);
    logic [C-1:0] t;
    t = C'(v);
    return DW'($signed(t));
  endfunction

  state_t                state_r;
  nps_pkg::job_t         jr_r;
  logic signed [DW-1:0]  qx_r, qy_r;
  logic signed [DW-1:0]  dx_r, dy_r, wx_r, wy_r, ux_r, uy_r;
  logic signed [PRW-1:0] dxdx_r, dydy_r, wxdx_r, wydy_r, wxdy_r, wydx_r;
  logic signed [PRW-1:0] wxwx_r, wywy_r, uxux_r, uyuy_r;
  logic [SW-1:0]         len2_r, da_r, db_r, d_r;
  logic signed [SGW-1:0] dot_r, cross_r;
  logic [QW-1:0]         mcand_r, acc_r, dvd_r;
  logic [MW-1:0]         mplier_r;
  logic [SW-1:0]         rem_r, quo_r;
  logic [CW-1:0]         cnt_r;
  logic [SW-1:0]         path_min_r, best_dist_r;
  logic [P-1:0]          best_path_r, path_cnt_r;
  logic                  any_valid_r;
  logic                  out_valid_r, out_found_r;
  logic [IW-1:0]         out_idx_r;
  logic [OW-1:0]         out_dist_r;

  logic signed [DW-1:0]  ax_c, ay_c, bx_c, by_c;
  logic signed [SGW-1:0] len2_s, da_s, db_s;
  logic [SGW-1:0]        mag_s;
  logic [SW:0]           rem_sh;
  logic [SW-1:0]         pmin, fin_best;
  logic [P-1:0]          fin_path;
  logic                  upd_best, fin_any, pop, out_block, load_out;

  assign job_ready = (state_r == S_IDLE);
  assign pop       = job_valid && job_ready;

  assign ax_c = to_coord(job.ax);
  assign ay_c = to_coord(job.ay);
  assign bx_c = to_coord(job.bx);
  assign by_c = to_coord(job.by);

  assign len2_s = SGW'(dxdx_r) + SGW'(dydy_r);
  assign da_s   = SGW'(wxwx_r) + SGW'(wywy_r);
  assign db_s   = SGW'(uxux_r) + SGW'(uyuy_r);
  assign mag_s  = cross_r[SGW-1] ? $unsigned(-cross_r) : $unsigned(cross_r);
  assign rem_sh = {rem_r, dvd_r[QW-1]};

  assign pmin      = (d_r < path_min_r) ? d_r : path_min_r;
  assign upd_best  = jr_r.path_end && jr_r.path_valid && (pmin < best_dist_r);
  assign fin_best  = upd_best ? pmin : best_dist_r;
  assign fin_path  = upd_best ? path_cnt_r : best_path_r;
  assign fin_any   = any_valid_r || (jr_r.path_end && jr_r.path_valid);
  assign out_block = jr_r.search_last && out_valid_r && !out_ch.ready;
  assign load_out  = (state_r == S_UPD) && !out_block && jr_r.search_last;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.best_index  = out_idx_r;
  assign out_ch.min_sq_dist = out_dist_r;
  assign out_ch.found       = out_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qx_r        <= '0;
      qy_r        <= '0;
      path_min_r  <= DIST_ONES;
      best_dist_r <= DIST_ONES;
      best_path_r <= '0;
      path_cnt_r  <= '0;
      any_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            jr_r <= job;
            if (job.op == nps_pkg::OP_START) begin
              qx_r        <= ax_c;
              qy_r        <= ay_c;
              path_min_r  <= DIST_ONES;
              best_dist_r <= DIST_ONES;
              best_path_r <= '0;
              path_cnt_r  <= '0;
              any_valid_r <= 1'b0;
            end else begin
              dx_r <= bx_c - ax_c;
              dy_r <= by_c - ay_c;
              wx_r <= qx_r - ax_c;
              wy_r <= qy_r - ay_c;
              ux_r <= qx_r - bx_c;
              uy_r <= qy_r - by_c;
              d_r  <= DIST_ONES;
              state_r <= job.seg ? S_MUL : S_UPD;
            end
          end
        end
        S_MUL: begin
          dxdx_r  <= PRW'(dx_r) * PRW'(dx_r);
          dydy_r  <= PRW'(dy_r) * PRW'(dy_r);
          wxdx_r  <= PRW'(wx_r) * PRW'(dx_r);
          wydy_r  <= PRW'(wy_r) * PRW'(dy_r);
          wxdy_r  <= PRW'(wx_r) * PRW'(dy_r);
          wydx_r  <= PRW'(wy_r) * PRW'(dx_r);
          wxwx_r  <= PRW'(wx_r) * PRW'(wx_r);
          wywy_r  <= PRW'(wy_r) * PRW'(wy_r);
          uxux_r  <= PRW'(ux_r) * PRW'(ux_r);
          uyuy_r  <= PRW'(uy_r) * PRW'(uy_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          len2_r  <= SW'(len2_s);
          da_r    <= SW'(da_s);
          db_r    <= SW'(db_s);
          dot_r   <= SGW'(wxdx_r) + SGW'(wydy_r);
          cross_r <= SGW'(wxdy_r) - SGW'(wydx_r);
          state_r <= S_CLS;
        end
        S_CLS: begin
          if (len2_r == '0 || dot_r[SGW-1]) begin
            d_r     <= da_r;
            state_r <= S_UPD;
          end else if ($unsigned(dot_r) > SGW'(len2_r)) begin
            d_r     <= db_r;
            state_r <= S_UPD;
          end else begin
            mcand_r  <= QW'(mag_s);
            mplier_r <= MW'(mag_s);
            acc_r    <= '0;
            cnt_r    <= CW'(MW);
            state_r  <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_r == '0) begin
            dvd_r   <= acc_r;
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= CW'(QW);
            state_r <= S_DIV;
          end else begin
            if (mplier_r[0]) begin
              acc_r <= acc_r + mcand_r;
            end
            mcand_r  <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
            cnt_r    <= cnt_r - CW'(1);
          end
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            d_r     <= quo_r;
            state_r <= S_UPD;
          end else begin
            if (rem_sh >= (SW + 1)'(len2_r)) begin
              rem_r <= SW'(rem_sh - (SW + 1)'(len2_r));
              quo_r <= {quo_r[SW-2:0], 1'b1};
            end else begin
              rem_r <= SW'(rem_sh);
              quo_r <= {quo_r[SW-2:0], 1'b0};
            end
            dvd_r <= dvd_r << 1;
            cnt_r <= cnt_r - CW'(1);
          end
        end
        S_UPD: begin
          if (!out_block) begin
            if (jr_r.search_last) begin
              out_valid_r <= 1'b1;
              out_idx_r   <= IW'(fin_path);
              out_dist_r  <= OW'(fin_best);
              out_found_r <= fin_any;
              path_min_r  <= DIST_ONES;
              best_dist_r <= DIST_ONES;
              best_path_r <= '0;
              path_cnt_r  <= '0;
              any_valid_r <= 1'b0;
            end else if (jr_r.path_end) begin
              path_min_r  <= DIST_ONES;
              best_dist_r <= fin_best;
              best_path_r <= fin_path;
              path_cnt_r  <= path_cnt_r + P'(1);
              any_valid_r <= fin_any;
            end else begin
              path_min_r <= pmin;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (len2_r != '0))
    else $error("divider running with zero segment length");

  a_best_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !any_valid_r |-> (best_dist_r == DIST_ONES && best_path_r == '0))
    else $error("best distance set without a valid path");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && job.op == nps_pkg::OP_START) |=> (path_cnt_r == '0 && !any_valid_r))
    else $error("start job did not clear the search");

  a_result_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_UPD))
    else $error("result loaded outside the update step");

endmodule

// File: hdl/nearest_polyline_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_polyline_search: nearest path to a query point
// Finds, over a stream of polyline vertices, the path whose squared distance
// to the query point is smallest, and reports it once per search.
//
//   channel  | dir | payload                                  | transaction
//   in_ch    | in  | cmd, x, y, path_last, search_last        | valid & ready
//   out_ch   | out | best_index, min_sq_dist, found           | valid & ready
//
// Start commands are taken in the idle state; a vertex without a segment
// passes through the update state. Segments outside the projection range
// pass the multiply, sum, classify and update states; interior segments also
// run the shift-add squarer and the restoring divider, one bit per cycle.
// A two-entry job queue lets input transactions enter while the engine works.
// Reset is synchronous; the engine waits at the last job of a search while the result register is full and not taken.
// ----------------------------------------------------------------------------
module nearest_polyline_search #(
  parameter int PATH_INDEX_BITS = nps_pkg::PATH_INDEX_BITS_DEF,
  parameter int COORD_BITS      = nps_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nps_in_if.sink    in_ch,
  nps_out_if.source out_ch
);

  nps_pkg::job_t front_job, back_job;
  logic          front_valid, front_ready, back_valid, back_ready;

  nps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  nps_queue #(
    .DEPTH (nps_pkg::QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_job    (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  nps_back #(
    .PATH_INDEX_BITS (PATH_INDEX_BITS),
    .COORD_BITS      (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .out_ch    (out_ch)
  );

endmodule
